// ===== design/node_learning_table_with_aging_assert.svh =====
// Assertion macros shared by the checker of the neighbor table.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef NODE_LEARNING_TABLE_WITH_AGING_ASSERT_SVH
`define NODE_LEARNING_TABLE_WITH_AGING_ASSERT_SVH

// same-cycle implication
`define NLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/nlt_pkg.sv =====
// Types and constants of the neighbor learning table.
// Used by the controller, the datapath, the top level and the checker.
package nlt_pkg;

	typedef enum logic [1:0] {
		OP_OBSERVE = 2'd0,
		OP_EXPIRE  = 2'd1,
		OP_LOOKUP  = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [47:0] last_heard;
		logic [47:0] created;
		logic [7:0]  rssi;
		logic [7:0]  snr;
		logic [2:0]  hops;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic load;
		logic clr_wr;
		logic scan_rd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
	} stat_t;

endpackage

// ===== design/nlt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module nlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/nlt_ctrl.sv =====
// Sequencer of the neighbor table: clearing pass, slot scan, result.
// Depends on nlt_pkg.
module nlt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    opcode,
	input  nlt_pkg::stat_t st,
	output logic          busy,
	output logic          done,
	output nlt_pkg::cmd_t  cmd
);
	import nlt_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_RESULT);
			unique case (state_q)
				S_CLEAR: begin
					if (st.cnt_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) state_q <= (opcode == OP_NONE) ? S_RESULT : S_SCAN;
				end
				S_SCAN: begin
					if (st.cnt_last) state_q <= S_DRAIN;
				end
				S_DRAIN:  state_q <= S_RESULT;
				S_RESULT: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load    = (state_q == S_IDLE) && start;
		cmd.clr_wr  = (state_q == S_CLEAR);
		cmd.scan_rd = (state_q == S_SCAN);
		cmd.finish  = (state_q == S_RESULT);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== design/nlt_datapath.sv =====
// Datapath of the neighbor table: entry RAM, slot counter, match and age
// logic, live count and result registers. Depends on nlt_pkg and nlt_ram.
module nlt_datapath #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nlt_pkg::cmd_t       cmd,
	output nlt_pkg::stat_t      st,
	input  logic               cfg_we,
	input  logic [47:0]        cfg_wdata,
	input  logic [1:0]         opcode,
	input  logic [31:0]        node_number,
	input  logic [47:0]        now_ms,
	input  logic signed [7:0]  rssi,
	input  logic signed [7:0]  snr_quarter_db,
	input  logic [2:0]         hops_initial,
	input  logic [2:0]         hops_left,
	output logic [1:0]         status,
	output logic [7:0]         slot_index,
	output logic               is_new,
	output logic [8:0]         entry_count,
	output logic [8:0]         removed_count,
	output logic signed [7:0]  stored_rssi,
	output logic signed [7:0]  stored_snr_quarter_db,
	output logic [2:0]         stored_hops,
	output logic [47:0]        last_heard,
	output logic [47:0]        created_ms
);
	import nlt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = $clog2(TABLE_DEPTH + 1);

	op_t          op_q;
	logic [31:0]  key_q;
	logic [47:0]  now_q;
	logic [7:0]   rssi_q;
	logic [7:0]   snr_q;
	logic [2:0]   hs_q;
	logic [2:0]   hl_q;
	logic [47:0]  age_q;

	logic [AW-1:0] cnt_q;
	logic [AW-1:0] addr_s1;
	logic          rd_vld_s1;
	logic          cnt_last;

	logic          hit_q;
	logic [AW-1:0] hit_slot_q;
	entry_t        hit_rec_q;
	logic          free_q;
	logic [AW-1:0] free_slot_q;
	logic [LW-1:0] removed_q;
	logic [LW-1:0] live_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	entry_t             ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_rec;

	logic [47:0]   rd_age;
	logic          expired;
	logic          match;
	entry_t        new_rec;
	logic [AW-1:0] slot_sel;
	logic          obs_ok;
	logic [LW-1:0] live_inc;

	status_t      status_q;
	logic [7:0]   slot_q;
	logic         is_new_q;
	logic [8:0]   count_q;
	logic [8:0]   removed_out_q;
	logic [7:0]   srssi_q;
	logic [7:0]   ssnr_q;
	logic [2:0]   shops_q;
	logic [47:0]  lh_q;
	logic [47:0]  fs_q;

	nlt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	assign rd_rec   = entry_t'(ram_rdata);
	assign cnt_last = (cnt_q == AW'(TABLE_DEPTH - 1));
	assign st.cnt_last = cnt_last;

	assign rd_age  = now_q - rd_rec.last_heard;
	assign expired = rd_rec.valid && (rd_age > age_q);
	assign match   = rd_rec.valid && (rd_rec.key == key_q);
	assign obs_ok  = hit_q || free_q;
	assign live_inc = live_q + LW'(!hit_q);

	always_comb begin
		slot_sel           = hit_q ? hit_slot_q : free_slot_q;
		new_rec.valid      = 1'b1;
		new_rec.key        = key_q;
		new_rec.last_heard = now_q;
		new_rec.created    = hit_q ? hit_rec_q.created : now_q;
		new_rec.rssi       = rssi_q;
		new_rec.snr        = snr_q;
		if (hs_q > hl_q) begin
			new_rec.hops = hs_q - hl_q;
		end else begin
			new_rec.hops = hit_q ? hit_rec_q.hops : 3'd0;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		if (cmd.clr_wr) begin
			ram_we = 1'b1;
		end else if (rd_vld_s1 && op_q == OP_EXPIRE && expired) begin
			ram_we          = 1'b1;
			ram_waddr       = addr_s1;
			ram_wdata       = rd_rec;
			ram_wdata.valid = 1'b0;
		end else if (cmd.finish && op_q == OP_OBSERVE && obs_ok) begin
			ram_we    = 1'b1;
			ram_waddr = slot_sel;
			ram_wdata = new_rec;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
			live_q    <= '0;
			age_q     <= '0;
			op_q      <= OP_NONE;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cfg_we) age_q <= cfg_wdata;
			if (cmd.clr_wr || cmd.scan_rd) begin
				cnt_q <= cnt_last ? '0 : cnt_q + AW'(1);
			end
			if (cmd.load) begin
				op_q      <= op_t'(opcode);
				hit_q     <= 1'b0;
				free_q    <= 1'b0;
				removed_q <= '0;
			end else if (rd_vld_s1) begin
				if (op_q == OP_EXPIRE) begin
					if (expired) begin
						removed_q <= removed_q + LW'(1);
						live_q    <= live_q - LW'(1);
					end
				end else begin
					if (!hit_q && match) hit_q <= 1'b1;
					if (!free_q && !rd_rec.valid) free_q <= 1'b1;
				end
			end else if (cmd.finish && op_q == OP_OBSERVE && obs_ok) begin
				live_q <= live_inc;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		if (cmd.load) begin
			key_q  <= node_number;
			now_q  <= now_ms;
			rssi_q <= rssi;
			snr_q  <= snr_quarter_db;
			hs_q   <= hops_initial;
			hl_q   <= hops_left;
		end
		if (rd_vld_s1 && op_q != OP_EXPIRE) begin
			if (!hit_q && match) begin
				hit_slot_q <= addr_s1;
				hit_rec_q  <= rd_rec;
			end
			if (!free_q && !rd_rec.valid) free_slot_q <= addr_s1;
		end
		if (cmd.finish) begin
			status_q      <= ST_OK;
			slot_q        <= '0;
			is_new_q      <= 1'b0;
			count_q       <= 9'(live_q);
			removed_out_q <= '0;
			srssi_q       <= '0;
			ssnr_q        <= '0;
			shops_q       <= '0;
			lh_q          <= '0;
			fs_q          <= '0;
			case (op_q)
				OP_OBSERVE: begin
					if (obs_ok) begin
						slot_q   <= 8'(slot_sel);
						is_new_q <= !hit_q;
						count_q  <= 9'(live_inc);
						srssi_q  <= new_rec.rssi;
						ssnr_q   <= new_rec.snr;
						shops_q  <= new_rec.hops;
						lh_q     <= new_rec.last_heard;
						fs_q     <= new_rec.created;
					end else begin
						status_q <= ST_FULL;
					end
				end
				OP_EXPIRE: begin
					removed_out_q <= 9'(removed_q);
				end
				OP_LOOKUP: begin
					if (hit_q) begin
						slot_q  <= 8'(hit_slot_q);
						srssi_q <= hit_rec_q.rssi;
						ssnr_q  <= hit_rec_q.snr;
						shops_q <= hit_rec_q.hops;
						lh_q    <= hit_rec_q.last_heard;
						fs_q    <= hit_rec_q.created;
					end else begin
						status_q <= ST_NOT_FOUND;
					end
				end
				default: ;
			endcase
		end
	end

	assign status                = status_q;
	assign slot_index            = slot_q;
	assign is_new                = is_new_q;
	assign entry_count           = count_q;
	assign removed_count         = removed_out_q;
	assign stored_rssi           = $signed(srssi_q);
	assign stored_snr_quarter_db = $signed(ssnr_q);
	assign stored_hops           = shops_q;
	assign last_heard            = lh_q;
	assign created_ms            = fs_q;

endmodule

// ===== design/node_learning_table_with_aging.sv =====
// Neighbor learning table with aging: top level.
// Joins nlt_ctrl and nlt_datapath; depends on nlt_pkg.
//
// Usage:
//   Command word: opcode, node_number, now_ms, rssi, snr_quarter_db,
//   hops_initial, hops_left, taken at a clock edge with start high, busy low.
//   Result word: status .. created_ms, valid for one cycle with done high.
//   Exactly one result per command. The receiver cannot stall it.
//   Config: cfg_we/cfg_wdata write expire_age; write only while idle.
// Sequence:
//   Every command except the unused opcode scans all TABLE_DEPTH slots
//   through the single read port of the entry RAM, one slot per cycle;
//   the controller then passes through S_DRAIN and S_RESULT before done
//   rises, and a new command can be taken at the edge that ends the done
//   cycle. The unused opcode goes from idle straight to S_RESULT.
// Reset:
//   arst_n clears control state, live count and expire_age, then a clearing
//   pass writes every RAM entry invalid, one per cycle, and busy stays high
//   until the pass has written the last entry.
module node_learning_table_with_aging #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               cfg_we,
	input  logic [47:0]        cfg_wdata,
	input  logic [1:0]         opcode,
	input  logic [31:0]        node_number,
	input  logic [47:0]        now_ms,
	input  logic signed [7:0]  rssi,
	input  logic signed [7:0]  snr_quarter_db,
	input  logic [2:0]         hops_initial,
	input  logic [2:0]         hops_left,
	output logic [1:0]         status,
	output logic [7:0]         slot_index,
	output logic               is_new,
	output logic [8:0]         entry_count,
	output logic [8:0]         removed_count,
	output logic signed [7:0]  stored_rssi,
	output logic signed [7:0]  stored_snr_quarter_db,
	output logic [2:0]         stored_hops,
	output logic [47:0]        last_heard,
	output logic [47:0]        created_ms
);
	import nlt_pkg::*;

	cmd_t  cmd;
	stat_t st;

	nlt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.st     (st),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	nlt_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.st                    (st),
		.cfg_we                (cfg_we),
		.cfg_wdata             (cfg_wdata),
		.opcode                (opcode),
		.node_number           (node_number),
		.now_ms                (now_ms),
		.rssi                  (rssi),
		.snr_quarter_db        (snr_quarter_db),
		.hops_initial          (hops_initial),
		.hops_left             (hops_left),
		.status                (status),
		.slot_index            (slot_index),
		.is_new                (is_new),
		.entry_count           (entry_count),
		.removed_count         (removed_count),
		.stored_rssi           (stored_rssi),
		.stored_snr_quarter_db (stored_snr_quarter_db),
		.stored_hops           (stored_hops),
		.last_heard            (last_heard),
		.created_ms            (created_ms)
	);

endmodule

// ===== design/nlt_checker.sv =====
// Port-level checks of the neighbor table, bound to the top level.
// Depends on nlt_pkg and node_learning_table_with_aging_assert.svh.
`include "node_learning_table_with_aging_assert.svh"

module nlt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic [7:0]         slot_index,
	input logic               is_new,
	input logic [8:0]         entry_count,
	input logic [8:0]         removed_count
);
	import nlt_pkg::*;

	logic fail_word;
	logic fail_clean;

	assign fail_word  = done && (status != ST_OK);
	assign fail_clean = !is_new && (removed_count == 9'd0) && (slot_index == 8'd0);

	`NLT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "no busy after accept")
	`NLT_ASSERT_NOW(a_done_idle, done, !busy, "result word while busy")
	`NLT_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`NLT_ASSERT_NOW(a_fail_clean, fail_word, fail_clean, "failed word carries data")
	`NLT_ASSERT_NOW(a_new_counted, done && is_new, entry_count != 9'd0, "new entry, zero count")

endmodule

bind node_learning_table_with_aging nlt_checker u_nlt_checker (.*);
